// ----- rtl/pcm_mix_pkg.sv -----
// ----------------------------------------------------------------------------
// pcm_mix_pkg
// Shared sizes, request codes and register indexes of the pcm sample mixer.
// ----------------------------------------------------------------------------
package pcm_mix_pkg;

    localparam int CHANNELS     = 4;
    localparam int SAMPLE_DEPTH = 8192;

    localparam int ADDR_W    = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BIT_CNT_W = $clog2(LEN_W);
    localparam int ACT_BITS  = (CHANNELS > 4) ? CHANNELS : 4;

    // fixed field widths
    localparam int REQ_W        = 2;
    localparam int CH_SEL_W     = 2;
    localparam int STORE_ADDR_W = 13;
    localparam int SAMPLE_W     = 8;
    localparam int ACT_W        = 4;
    localparam int LEN_REG_W    = 14;
    localparam int LOOP_W       = 4;
    localparam int LEN_REGS     = 4;

    localparam int FADE_W     = 3;
    localparam int FADE_STEPS = 4;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int RESULT_W    = SAMPLE_W + ACT_W;

    localparam logic [LEN_REG_W-1:0] LEN_RESET  = 14'd8192;
    localparam logic [LOOP_W-1:0]    LOOP_RESET = 4'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 2'd0,
        REQ_TRIGGER = 2'd1,
        REQ_STOP    = 2'd2,
        REQ_WRITE   = 2'd3
    } req_t;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_CH3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MASK  = 3'd4;

endpackage

// ----- rtl/pcm_sample_mixer.sv -----
// ----------------------------------------------------------------------------
// pcm_sample_mixer
// Four-channel signed 8-bit sample player and mixer with banked sample stores.
// ----------------------------------------------------------------------------
// path: a tick beat is registered into the second stage (store read, flags), then into the output queue
// throughput: one beat per cycle while s_tready is high; a 2-entry output queue parts the two sides
// after a length write the wrap points are recomputed by a serial remainder
//   unit, one bit a cycle, with s_tready low while it runs
// reset: aresetn synchronous, active low; sample stores are not cleared
module pcm_sample_mixer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [1:0] channel_sel, [14:2] store_address, [22:15] store_value
    input  logic [pcm_mix_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] req_type
    input  logic [pcm_mix_pkg::REQ_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] mixed_sample, [11:8] active_mask
    output logic [pcm_mix_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [pcm_mix_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcm_mix_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import pcm_mix_pkg::*;

    // input fields
    logic [CH_SEL_W-1:0]     s_ch;
    logic [STORE_ADDR_W-1:0] s_addr;
    logic [SAMPLE_W-1:0]     s_value;
    req_t                    s_req;
    logic                    acc;
    logic                    ch_ok;
    logic                    addr_ok;

    assign s_ch    = s_tdata[1:0];
    assign s_addr  = s_tdata[14:2];
    assign s_value = s_tdata[22:15];
    assign s_req   = req_t'(s_tuser);
    assign acc     = s_tvalid && s_tready;
    assign ch_ok   = 32'(s_ch) < CHANNELS;
    assign addr_ok = 32'(s_addr) < SAMPLE_DEPTH;

    // configuration
    logic [LEN_REG_W-1:0] length_reg [LEN_REGS];
    logic [LOOP_W-1:0]    loop_mask_reg;

    // channel state
    logic [ADDR_W-1:0]   pos_reg      [CHANNELS];
    logic [ADDR_W-1:0]   pos_next     [CHANNELS];
    logic [CHANNELS-1:0] playing_reg;
    logic [CHANNELS-1:0] playing_next;
    logic [FADE_W-1:0]   fade_reg     [CHANNELS];
    logic [FADE_W-1:0]   fade_next    [CHANNELS];
    logic [ADDR_W-1:0]   wrap_reg     [CHANNELS];
    logic [LEN_W-1:0]    eff_len      [CHANNELS];
    logic [CHANNELS-1:0] loop_bit;

    // second stage
    logic                p1_valid_reg;
    logic [CHANNELS-1:0] p1_play_reg;
    logic [CHANNELS-1:0] p1_fade_reg;
    logic [FADE_W-1:0]   p1_fc_reg    [CHANNELS];
    logic [CHANNELS-1:0] play_en;
    logic [CHANNELS-1:0] fade_en;
    logic [FADE_W-1:0]   fc_pass      [CHANNELS];
    logic [SAMPLE_W-1:0] rd_data      [CHANNELS];
    logic [SAMPLE_W-1:0] last_reg     [CHANNELS];
    logic [SAMPLE_W-1:0] mix_sum;
    logic [ACT_BITS-1:0] mix_act;

    // output queue
    logic [RESULT_W-1:0] fifo_q [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic                pop;
    logic [2:0]          occ;

    // remainder unit
    logic                 busy_reg;
    logic [CH_W-1:0]      div_ch_reg;
    logic [BIT_CNT_W-1:0] div_bit_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     div_dividend;
    logic [LEN_W:0]       div_trial;
    logic [LEN_W-1:0]     div_rem_next;
    logic                 len_write;

    // per-channel length clamp and loop bit
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        if (g < LEN_REGS) begin : g_cfg
            assign eff_len[g] = (length_reg[g] == '0) ? LEN_W'(1) :
                                (32'(length_reg[g]) > SAMPLE_DEPTH) ? LEN_W'(SAMPLE_DEPTH) :
                                LEN_W'(length_reg[g]);
            assign loop_bit[g] = loop_mask_reg[g];
        end else begin : g_nocfg
            assign eff_len[g]  = LEN_W'(SAMPLE_DEPTH);
            assign loop_bit[g] = 1'b0;
        end
    end

    // one sample bank per channel
    for (genvar g = 0; g < CHANNELS; g++) begin : g_bank
        logic [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
        logic [SAMPLE_W-1:0] rd_q;
        logic                we;

        assign we = acc && (s_req == REQ_WRITE) && ch_ok && (32'(s_ch) == g) && addr_ok;

        always_ff @(posedge aclk) begin
            if (we) begin
                mem[ADDR_W'(s_addr)] <= s_value;
            end
            if (acc && (s_req == REQ_TICK)) begin
                rd_q <= mem[pos_reg[g]];
            end
        end

        assign rd_data[g] = rd_q;
    end

    // handshake
    assign pop      = m_tvalid && m_tready;
    assign occ      = 3'(count_reg) + 3'(p1_valid_reg);
    assign s_tready = !busy_reg && ((occ <= 3'd1) || ((occ == 3'd2) && pop));
    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = M_TDATA_W'(fifo_q[rd_ptr_reg]);

    // first stage: control state update at accept
    always_comb begin
        logic [LEN_W-1:0] pos_inc;
        pos_inc      = '0;
        playing_next = playing_reg;
        play_en      = '0;
        fade_en      = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            pos_next[c]  = pos_reg[c];
            fade_next[c] = fade_reg[c];
            fc_pass[c]   = '0;
        end
        if (acc) begin
            case (s_req)
                REQ_TICK: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        pos_inc = {1'b0, pos_reg[c]} + LEN_W'(1);
                        if (playing_reg[c]) begin
                            play_en[c] = 1'b1;
                            if (pos_inc >= eff_len[c]) begin
                                if (loop_bit[c]) begin
                                    // past a shortened length: precomputed wrap point
                                    pos_next[c] = (pos_inc == eff_len[c]) ? '0 : wrap_reg[c];
                                end else begin
                                    playing_next[c] = 1'b0;
                                    fade_next[c]    = FADE_W'(FADE_STEPS);
                                    pos_next[c]     = pos_inc[ADDR_W-1:0];
                                end
                            end else begin
                                pos_next[c] = pos_inc[ADDR_W-1:0];
                            end
                        end else if (fade_reg[c] != '0) begin
                            fade_en[c]   = 1'b1;
                            fc_pass[c]   = fade_reg[c];
                            fade_next[c] = fade_reg[c] - FADE_W'(1);
                        end
                    end
                end
                REQ_TRIGGER: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (ch_ok && (32'(s_ch) == c)) begin
                            pos_next[c]     = '0;
                            playing_next[c] = 1'b1;
                        end
                    end
                end
                REQ_STOP: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (ch_ok && (32'(s_ch) == c)) begin
                            playing_next[c] = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // second stage: mix the read samples and fades
    always_comb begin
        logic signed [10:0] prod;
        logic signed [10:0] quot;
        logic [SAMPLE_W-1:0] s;
        prod    = '0;
        quot    = '0;
        s       = '0;
        mix_sum = '0;
        mix_act = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            prod = 11'($signed(last_reg[c])) * 11'($signed({1'b0, p1_fc_reg[c]}));
            // divide by four, truncating toward zero
            quot = (prod < 0) ? ((prod + 11'sd3) >>> 2) : (prod >>> 2);
            if (p1_play_reg[c]) begin
                s = rd_data[c];
            end else if (p1_fade_reg[c]) begin
                s = quot[SAMPLE_W-1:0];
            end else begin
                s = '0;
            end
            mix_sum    = mix_sum + s;
            mix_act[c] = p1_play_reg[c] || p1_fade_reg[c];
        end
    end

    // remainder of (pos + 1) by the length, one bit a cycle
    assign len_write    = cfg_wr_en && (cfg_index <= CFG_LENGTH_CH3);
    assign div_dividend = {1'b0, pos_reg[div_ch_reg]} + LEN_W'(1);
    assign div_trial    = {rem_reg, div_dividend[div_bit_reg]};
    assign div_rem_next = (div_trial >= {1'b0, eff_len[div_ch_reg]}) ?
                          LEN_W'(div_trial - {1'b0, eff_len[div_ch_reg]}) :
                          LEN_W'(div_trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < LEN_REGS; c++) begin
                length_reg[c] <= LEN_RESET;
            end
            loop_mask_reg <= LOOP_RESET;
            playing_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                pos_reg[c]   <= '0;
                fade_reg[c]  <= '0;
                wrap_reg[c]  <= '0;
                last_reg[c]  <= '0;
                p1_fc_reg[c] <= '0;
            end
            p1_valid_reg <= 1'b0;
            p1_play_reg  <= '0;
            p1_fade_reg  <= '0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
            busy_reg     <= 1'b0;
            div_ch_reg   <= '0;
            div_bit_reg  <= '0;
            rem_reg      <= '0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                if (len_write) begin
                    length_reg[cfg_index[1:0]] <= LEN_REG_W'(cfg_wr_data);
                end else if (cfg_index == CFG_LOOP_MASK) begin
                    loop_mask_reg <= LOOP_W'(cfg_wr_data);
                end
            end

            // wrap point sweep, restarted by every length write
            if (len_write) begin
                busy_reg    <= 1'b1;
                div_ch_reg  <= '0;
                div_bit_reg <= BIT_CNT_W'(LEN_W - 1);
                rem_reg     <= '0;
            end else if (busy_reg) begin
                if (div_bit_reg == '0) begin
                    wrap_reg[div_ch_reg] <= div_rem_next[ADDR_W-1:0];
                    rem_reg              <= '0;
                    div_bit_reg          <= BIT_CNT_W'(LEN_W - 1);
                    if (32'(div_ch_reg) == CHANNELS - 1) begin
                        busy_reg <= 1'b0;
                    end else begin
                        div_ch_reg <= div_ch_reg + CH_W'(1);
                    end
                end else begin
                    rem_reg     <= div_rem_next;
                    div_bit_reg <= div_bit_reg - BIT_CNT_W'(1);
                end
            end

            // channel state
            playing_reg <= playing_next;
            for (int c = 0; c < CHANNELS; c++) begin
                pos_reg[c]  <= pos_next[c];
                fade_reg[c] <= fade_next[c];
            end

            // stage hand-over
            p1_valid_reg <= acc && (s_req == REQ_TICK);
            p1_play_reg  <= play_en;
            p1_fade_reg  <= fade_en;
            for (int c = 0; c < CHANNELS; c++) begin
                p1_fc_reg[c] <= fc_pass[c];
                if (p1_valid_reg && p1_play_reg[c]) begin
                    last_reg[c] <= rd_data[c];
                end
            end

            // output queue
            if (p1_valid_reg) begin
                fifo_q[wr_ptr_reg] <= {mix_act[ACT_W-1:0], mix_sum};
                wr_ptr_reg         <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(p1_valid_reg) - 2'(pop);
        end
    end

    // the second stage always finds room in the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> (count_reg < 2'd2 || pop))
        else $error("output queue overflow");

    // no beat is taken while wrap points are recomputed
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("beat accepted during wrap sweep");

    // every accepted tick reaches the second stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && (s_req == REQ_TICK)) |=> p1_valid_reg)
        else $error("tick lost between stages");

    // a channel never plays and fades in the same tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && (p1_fade_reg != '0)) |-> ((p1_fade_reg & p1_play_reg) == '0))
        else $error("channel both playing and fading");

endmodule

// ----- tb/sv/pcm_sample_mixer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_sample_mixer_tb
// Self-checking bench for the four-channel sample mixer. A behavioural model
// of the channels (position, play flag, fade, sample stores) predicts every
// tick beat; a checker compares each output beat with the oldest prediction.
// Directed tests cover looping, one-shot fades, stop and trigger during a
// fade and the length limits, then bursty random traffic runs under several
// register settings, with random and long output stalls.
// ----------------------------------------------------------------------------
module pcm_sample_mixer_tb;
    import pcm_mix_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BEATS   = 130;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mixed;
        logic [ACT_W-1:0]    active;
    } mix_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // channel model
    logic signed [SAMPLE_W-1:0] pcm_mem_model [CHANNELS][SAMPLE_DEPTH];
    bit                         pcm_written   [CHANNELS][SAMPLE_DEPTH];
    int                         play_pos  [CHANNELS];
    bit                         play_on   [CHANNELS];
    int                         fade_left [CHANNELS];
    int                         fade_base [CHANNELS];
    logic [LEN_REG_W-1:0]       len_model [CHANNELS];
    logic [LOOP_W-1:0]          loop_model;

    mix_result_t mix_expected [$];
    mix_result_t want_mix;
    mix_result_t got_mix;
    int          err_count;
    int          cycle_count;
    int          hold_request;
    int          hold_left;
    int          stretch_left;
    int          rx_mode;
    int          rx_phase;
    logic [7:0]  stall_pattern;

    pcm_sample_mixer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic mix_result_t predict_tick();
        mix_result_t      res;
        int               sum;
        int               smp;
        int               p;
        int               len;
        logic [ACT_W-1:0] act;
        sum = 0;
        act = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            smp = 0;
            if (play_on[c]) begin
                len = int'(len_model[c]);
                if (len == 0) len = 1;
                if (len > SAMPLE_DEPTH) len = SAMPLE_DEPTH;
                p = play_pos[c];
                if (p >= SAMPLE_DEPTH) p = 0;
                smp = pcm_mem_model[c][p];
                fade_base[c] = smp;
                p++;
                if (p >= len) begin
                    if (loop_model[c]) begin
                        p = p % len;
                    end else begin
                        play_on[c] = 1'b0;
                        fade_left[c] = FADE_STEPS;
                    end
                end
                play_pos[c] = p;
                act[c] = 1'b1;
            end else if (fade_left[c] > 0) begin
                smp = (fade_base[c] * fade_left[c]) / FADE_STEPS;
                fade_left[c]--;
                act[c] = 1'b1;
            end
            sum += smp;
        end
        res.mixed  = sum[SAMPLE_W-1:0];
        res.active = act;
        return res;
    endfunction

    // next store entry that some playing channel is about to read unwritten
    function automatic bit find_unwritten(output int ch, output int adr);
        int p;
        ch = 0;
        adr = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (play_on[c]) begin
                p = play_pos[c];
                if (p >= SAMPLE_DEPTH) p = 0;
                if (!pcm_written[c][p]) begin
                    ch = c;
                    adr = p;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic send_beat(req_t req, logic [CH_SEL_W-1:0] ch,
                             logic [STORE_ADDR_W-1:0] adr, logic [SAMPLE_W-1:0] val);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {1'b0, val, adr, ch};
        do @(posedge aclk); while (!s_tready);
        case (req)
            REQ_TICK:    mix_expected.push_back(predict_tick());
            REQ_TRIGGER: begin
                play_pos[ch] = 0;
                play_on[ch]  = 1'b1;
            end
            REQ_STOP:    play_on[ch] = 1'b0;
            REQ_WRITE:   begin
                pcm_mem_model[ch][adr] = val;
                pcm_written[ch][adr]   = 1'b1;
            end
            default:     begin
            end
        endcase
    endtask

    // fills any store entry the tick would read before it was written
    task automatic send_tick();
        int ch;
        int adr;
        while (find_unwritten(ch, adr))
            send_beat(REQ_WRITE, ch[CH_SEL_W-1:0], adr[STORE_ADDR_W-1:0],
                      SAMPLE_W'($urandom));
        send_beat(REQ_TICK, CH_SEL_W'($urandom), STORE_ADDR_W'($urandom),
                  SAMPLE_W'($urandom));
    endtask

    task automatic sender_gap(int n);
        @(negedge aclk);
        s_tvalid = 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (mix_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        // a length write keeps the input stalled while wrap points are rebuilt
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_LOOP_MASK)
            loop_model = val[LOOP_W-1:0];
        else if (idx <= CFG_LENGTH_CH3)
            len_model[idx[1:0]] = val[LEN_REG_W-1:0];
    endtask

    task automatic write_length(int ch, logic [CFG_DATA_W-1:0] val);
        write_reg(CFG_IDX_W'(CFG_LENGTH_CH0 + ch), val);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 1;
        if (r == 2) return CFG_DATA_W'(SAMPLE_DEPTH);
        if (r == 3) return '1;
        if (r < 10) return CFG_DATA_W'($urandom_range(1, 4));
        return CFG_DATA_W'($urandom_range(2, 32));
    endfunction

    task automatic random_beat();
        int                      r;
        logic [STORE_ADDR_W-1:0] adr;
        r = $urandom_range(0, 99);
        adr = ($urandom_range(0, 9) < 7) ? STORE_ADDR_W'($urandom_range(0, 31)) :
                                           STORE_ADDR_W'($urandom_range(0, 8191));
        if (r < 58)
            send_tick();
        else if (r < 68)
            send_beat(REQ_TRIGGER, CH_SEL_W'($urandom), STORE_ADDR_W'($urandom),
                      SAMPLE_W'($urandom));
        else if (r < 75)
            send_beat(REQ_STOP, CH_SEL_W'($urandom), STORE_ADDR_W'($urandom),
                      SAMPLE_W'($urandom));
        else
            send_beat(REQ_WRITE, CH_SEL_W'($urandom), adr, SAMPLE_W'($urandom));
    endtask

    task automatic test_idle_tick();
        send_tick();
        wait_idle();
    endtask

    // reset settings: channel 0 loops over the full store
    task automatic test_looping_channel();
        send_beat(REQ_WRITE, 0, 0, 8'sd127);
        send_beat(REQ_WRITE, 3, '1, -8'sd128);
        send_beat(REQ_TRIGGER, 0, 0, 0);
        send_tick();
        send_tick();
        send_beat(REQ_STOP, 0, 0, 0);
        send_tick();
        wait_idle();
    endtask

    // stop during a fade lets it run on; trigger during a fade keeps the count
    task automatic test_one_shot_fade();
        write_length(1, 2);
        write_reg(CFG_LOOP_MASK, '0);
        send_beat(REQ_WRITE, 1, 0, -8'sd128);
        send_beat(REQ_WRITE, 1, 1, -8'sd127);
        send_beat(REQ_TRIGGER, 1, 0, 0);
        repeat (3) send_tick();
        send_beat(REQ_STOP, 1, 0, 0);
        send_tick();
        send_beat(REQ_TRIGGER, 1, 0, 0);
        send_tick();
        send_beat(REQ_STOP, 1, 0, 0);
        repeat (4) send_tick();
        wait_idle();
    endtask

    // zero length plays as one sample, oversize length as the full store
    task automatic test_length_limits();
        write_length(2, 0);
        write_length(3, '1);
        write_reg(CFG_LOOP_MASK, 4'b0100);
        send_beat(REQ_WRITE, 2, 0, 8'sd5);
        send_beat(REQ_TRIGGER, 2, 0, 0);
        send_beat(REQ_TRIGGER, 3, 0, 0);
        repeat (3) send_tick();
        send_beat(REQ_STOP, 2, 0, 0);
        send_beat(REQ_STOP, 3, 0, 0);
        send_beat(REQ_STOP, 0, 0, 0);
        send_tick();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int burst;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (ph == 0)
                    write_length(c, 1);
                else if (ph == 1)
                    write_length(c, CFG_DATA_W'((c == 0) ? 0 : (c == 1) ? SAMPLE_DEPTH :
                                                (c == 2) ? '1 : 3));
                else
                    write_length(c, pick_length());
            end
            write_reg(CFG_LOOP_MASK, CFG_DATA_W'((ph == 0) ? '1 : (ph == 1) ? '0 :
                                                 $urandom_range(0, 15)));
            burst = $urandom_range(1, 24);
            for (int i = 0; i < PHASE_BEATS; i++) begin
                random_beat();
                burst--;
                if (burst == 0) begin
                    if ($urandom_range(0, 3) != 0)
                        sender_gap($urandom_range(1, 8));
                    burst = $urandom_range(1, 24);
                end
            end
            wait_idle();
        end
    endtask

    // long output stall with the input still busy, then a full drain
    task automatic test_output_backpressure();
        send_beat(REQ_TRIGGER, 0, 0, 0);
        send_beat(REQ_TRIGGER, 2, 0, 0);
        hold_request = 300;
        repeat (60) send_tick();
        wait_idle();
        repeat (10) send_tick();
        wait_idle();
    endtask

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            if (stretch_left == 0) begin
                rx_mode       = $urandom_range(0, 2);
                stretch_left  = $urandom_range(5, 60);
                stall_pattern = 8'($urandom);
            end
            stretch_left--;
            rx_phase = (rx_phase + 1) % 8;
            case (rx_mode)
                0:       m_tready = 1'b1;
                1:       m_tready = ($urandom_range(0, 3) != 0);
                default: m_tready = stall_pattern[rx_phase];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_mix.mixed  = m_tdata[SAMPLE_W-1:0];
            got_mix.active = m_tdata[SAMPLE_W +: ACT_W];
            if (mix_expected.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected beat: mixed %0d active %b",
                             $signed(got_mix.mixed), got_mix.active);
            end else begin
                want_mix = mix_expected.pop_front();
                if (got_mix.mixed !== want_mix.mixed) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mixed_sample: expected %0d, got %0d",
                                 $signed(want_mix.mixed), $signed(got_mix.mixed));
                end
                if (got_mix.active !== want_mix.active) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("active_mask: expected %b, got %b",
                                 want_mix.active, got_mix.active);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("pcm_sample_mixer_tb: errors");
        $finish;
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_TICK;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_LENGTH_CH0;
        cfg_wr_data  = '0;
        err_count    = 0;
        hold_request = 0;
        hold_left    = 0;
        stretch_left = 0;
        rx_mode      = 0;
        rx_phase     = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            play_pos[c]  = 0;
            play_on[c]   = 1'b0;
            fade_left[c] = 0;
            fade_base[c] = 0;
            len_model[c] = LEN_RESET;
            for (int a = 0; a < SAMPLE_DEPTH; a++)
                pcm_written[c][a] = 1'b0;
        end
        loop_model = LOOP_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_tick();
        test_looping_channel();
        test_one_shot_fade();
        test_length_limits();
        test_random_traffic();
        test_output_backpressure();

        wait_idle();
        repeat (10) @(posedge aclk);
        if (err_count == 0 && mix_expected.size() == 0)
            $display("pcm_sample_mixer_tb: clean");
        else
            $display("pcm_sample_mixer_tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pcm_mix_pkg.sv
rtl/pcm_sample_mixer.sv
tb/sv/pcm_sample_mixer_tb.sv
